// File: sv/xcr_pkg.sv
// ----------------------------------------------------------------------------
// XMODEM checksum receiver package
// Shared constants, protocol bytes and the structures passed between the
// front end, the command queue and the back end.
// ----------------------------------------------------------------------------
package xcr_pkg;

    localparam int          CMD_DEPTH_DEF  = 4;

    localparam int          IN_DATA_W      = 8;
    localparam int          OUT_DATA_W     = 144;

    localparam logic [63:0] LOAD_BASE_RST  = 64'h0000_0002_0000_0000;

    localparam logic [1:0]  ACT_BYTE       = 2'd0;
    localparam logic [1:0]  ACT_TIMEOUT    = 2'd1;
    localparam logic [1:0]  ACT_START      = 2'd2;

    localparam logic [7:0]  B_SOH          = 8'h01;
    localparam logic [7:0]  B_EOT          = 8'h04;
    localparam logic [7:0]  B_ACK          = 8'h06;
    localparam logic [7:0]  B_NAK          = 8'h15;
    localparam logic [7:0]  B_CAN          = 8'h18;

    localparam logic [7:0]  PKT_LEN        = 8'd132;
    localparam logic [7:0]  SUM_POS        = 8'd131;
    localparam logic [7:0]  DATA_FIRST     = 8'd3;
    localparam logic [7:0]  DATA_LEN       = 8'd128;

    localparam int          WORD_IDX_W     = 4;
    localparam logic [3:0]  WORD_LAST      = 4'd15;
    localparam logic [2:0]  LANE_LAST      = 3'd7;
    localparam logic [63:0] WORD_STRIDE    = 64'd8;

    localparam logic [2:0]  ST_RUN         = 3'd0;
    localparam logic [2:0]  ST_EOT         = 3'd1;
    localparam logic [2:0]  ST_CANCEL      = 3'd2;
    localparam logic [2:0]  ST_SUM_ERR     = 3'd3;
    localparam logic [2:0]  ST_SEQ_ERR     = 3'd4;

    localparam logic        KIND_REPLY     = 1'b0;
    localparam logic        KIND_WRITE     = 1'b1;

    typedef struct packed {
        logic [1:0]  n_ack;
        logic        nak;
        logic        can;
        logic        wr;
        logic [2:0]  status;
        logic [31:0] offset;
    } cmd_t;

    typedef struct packed {
        logic                  en;
        logic [WORD_IDX_W-1:0] addr;
        logic [63:0]           data;
    } mem_wr_t;

    typedef struct packed {
        logic wr_done;
    } back_stat_t;

endpackage

// File: sv/xcr_front.sv
// ----------------------------------------------------------------------------
// XMODEM receiver front end
// Accepts received bytes, timeouts and session starts, tracks the packet and
// session state, assembles the data words for the back end's data store and
// queues one command per transaction that causes replies or writes.
// ----------------------------------------------------------------------------
module xcr_front
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [xcr_pkg::IN_DATA_W-1:0]    s_tdata,   // rx_byte[7:0]
    input  logic [1:0]                       s_tuser,   // action[1:0]
    output xcr_pkg::cmd_t                    cmd,
    output logic                             cmd_push,
    input  logic                             cmd_full,
    output xcr_pkg::mem_wr_t                 mem_wr,
    input  xcr_pkg::back_stat_t              back_stat
);

    logic        active_reg,  active_next;
    logic [7:0]  count_reg,   count_next;
    logic [7:0]  header_reg,  header_next;
    logic [7:0]  seq_reg,     seq_next;
    logic [7:0]  sum_reg,     sum_next;
    logic [7:0]  exp_seq_reg, exp_seq_next;
    logic        first_reg,   first_next;
    logic [31:0] offset_reg,  offset_next;
    logic        busy_reg,    busy_next;
    logic [63:0] word_reg,    word_next;

    logic        accept;
    logic [1:0]  action;
    logic [7:0]  rx_byte;
    logic [7:0]  count_inc;
    logic [7:0]  data_pos;
    logic [7:0]  seq_inc;
    logic [7:0]  sum_inc;

    assign s_tready  = !cmd_full && !busy_reg;
    assign accept    = s_tvalid && s_tready;
    assign action    = s_tuser;
    assign rx_byte   = s_tdata;
    assign count_inc = count_reg + 8'd1;
    assign data_pos  = count_reg - xcr_pkg::DATA_FIRST;
    assign seq_inc   = exp_seq_reg + 8'd1;
    assign sum_inc   = sum_reg + rx_byte;

    always_comb
    begin
        active_next  = active_reg;
        count_next   = count_reg;
        header_next  = header_reg;
        seq_next     = seq_reg;
        sum_next     = sum_reg;
        exp_seq_next = exp_seq_reg;
        first_next   = first_reg;
        offset_next  = offset_reg;
        busy_next    = busy_reg && !back_stat.wr_done;
        word_next    = word_reg;
        cmd_push     = 1'b0;
        cmd          = '0;
        cmd.offset   = offset_reg;
        cmd.status   = xcr_pkg::ST_RUN;
        mem_wr.en    = 1'b0;
        mem_wr.addr  = data_pos[6:3];
        mem_wr.data  = {rx_byte, word_reg[55:0]};

        if (accept)
        begin
            case (action)
                xcr_pkg::ACT_START:
                begin
                    active_next  = 1'b1;
                    count_next   = '0;
                    exp_seq_next = '0;
                    first_next   = 1'b0;
                    offset_next  = '0;
                end
                xcr_pkg::ACT_TIMEOUT:
                begin
                    if (active_reg)
                    begin
                        cmd_push = 1'b1;
                        if (count_reg == 8'd0)
                        begin
                            cmd.nak   = !first_reg;
                            cmd.n_ack = first_reg ? 2'd2 : 2'd0;
                        end
                        else
                        begin
                            cmd.n_ack  = 2'd1;
                            count_next = '0;
                            if (header_reg == xcr_pkg::B_EOT)
                            begin
                                cmd.status  = xcr_pkg::ST_EOT;
                                active_next = 1'b0;
                            end
                            else if (header_reg == xcr_pkg::B_CAN)
                            begin
                                cmd.status  = xcr_pkg::ST_CANCEL;
                                active_next = 1'b0;
                            end
                        end
                    end
                end
                xcr_pkg::ACT_BYTE:
                begin
                    if (active_reg)
                    begin
                        if (count_reg == 8'd0)
                        begin
                            header_next = rx_byte;
                            sum_next    = '0;
                        end
                        else if (count_reg == 8'd1)
                        begin
                            seq_next = rx_byte;
                        end
                        else if (count_reg inside {[xcr_pkg::DATA_FIRST:
                                                    xcr_pkg::SUM_POS - 8'd1]})
                        begin
                            sum_next = sum_inc;
                            word_next[{data_pos[2:0], 3'b000} +: 8] = rx_byte;
                            mem_wr.en = (data_pos[2:0] == xcr_pkg::LANE_LAST);
                        end
                        count_next = count_inc;

                        if (count_inc >= xcr_pkg::PKT_LEN)
                        begin
                            count_next = '0;
                            cmd_push   = 1'b1;
                            first_next = 1'b1;
                            cmd.n_ack  = first_reg ? 2'd1 : 2'd3;
                            if (header_reg == xcr_pkg::B_SOH)
                            begin
                                if (sum_reg != rx_byte)
                                begin
                                    cmd.can     = 1'b1;
                                    cmd.status  = xcr_pkg::ST_SUM_ERR;
                                    active_next = 1'b0;
                                end
                                else
                                begin
                                    exp_seq_next = seq_inc;
                                    if (seq_inc != seq_reg)
                                    begin
                                        cmd.can     = 1'b1;
                                        cmd.status  = xcr_pkg::ST_SEQ_ERR;
                                        active_next = 1'b0;
                                    end
                                    else
                                    begin
                                        cmd.wr      = 1'b1;
                                        busy_next   = 1'b1;
                                        offset_next = offset_reg
                                                      + {24'd0, xcr_pkg::DATA_LEN};
                                    end
                                end
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            count_reg   <= '0;
            header_reg  <= '0;
            seq_reg     <= '0;
            sum_reg     <= '0;
            exp_seq_reg <= '0;
            first_reg   <= 1'b0;
            offset_reg  <= '0;
            busy_reg    <= 1'b0;
        end
        else
        begin
            active_reg  <= active_next;
            count_reg   <= count_next;
            header_reg  <= header_next;
            seq_reg     <= seq_next;
            sum_reg     <= sum_next;
            exp_seq_reg <= exp_seq_next;
            first_reg   <= first_next;
            offset_reg  <= offset_next;
            busy_reg    <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

`ifndef SYNTHESIS
    // The data store must not change while a packet's words are being read out.
    a_no_store_write_while_draining: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr.en |-> !busy_reg)
        else $error("data store written while writes are draining");
`endif

endmodule

// File: sv/xcr_cmd_fifo.sv
// ----------------------------------------------------------------------------
// XMODEM receiver command queue
// Short first-in first-out queue of commands from the front end to the back
// end, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module xcr_cmd_fifo
#(
    parameter int DEPTH = xcr_pkg::CMD_DEPTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  xcr_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output xcr_pkg::cmd_t pop_data,
    output logic          empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    xcr_pkg::cmd_t entry_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("command pushed into a full queue");
`endif

endmodule

// File: sv/xcr_back.sv
// ----------------------------------------------------------------------------
// XMODEM receiver back end
// Holds the data store and the load base register, takes commands from the
// queue and expands each into reply bytes and data word writes through a
// registered output stage.
// ----------------------------------------------------------------------------
module xcr_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load_base_we,
    input  logic [63:0]                       load_base_wdata,
    input  xcr_pkg::cmd_t                     cmd,
    input  logic                              cmd_empty,
    output logic                              cmd_pop,
    input  xcr_pkg::mem_wr_t                  mem_wr,
    output xcr_pkg::back_stat_t               back_stat,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [xcr_pkg::OUT_DATA_W-1:0]    m_tdata,   // tx_byte[7:0], write_addr[71:8],
                                                         // write_data[135:72],
                                                         // session_status[138:136]
    output logic                              m_tuser,   // kind
    output logic                              m_tlast
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_REPLY = 4'b0010,
        S_READ  = 4'b0100,
        S_WRITE = 4'b1000
    } state_t;

    logic [63:0] store_mem [2**xcr_pkg::WORD_IDX_W];

    state_t                         state_reg,   state_next;
    logic [1:0]                     ack_reg,     ack_next;
    logic                           nak_reg,     nak_next;
    logic                           can_reg,     can_next;
    logic                           wr_reg,      wr_next;
    logic [2:0]                     status_reg,  status_next;
    logic [63:0]                    addr_reg,    addr_next;
    logic [xcr_pkg::WORD_IDX_W-1:0] word_reg,    word_next;
    logic [63:0]                    base_reg;
    logic [63:0]                    rd_data_reg;

    logic                           valid_reg,   valid_next;
    logic                           kind_reg,    kind_next;
    logic                           last_reg,    last_next;
    logic [7:0]                     tx_reg,      tx_next;
    logic [63:0]                    waddr_reg,   waddr_next;
    logic [63:0]                    wdata_reg,   wdata_next;
    logic [2:0]                     ostat_reg,   ostat_next;

    logic                           out_free;
    logic                           load_out;

    assign out_free = !valid_reg || m_tready;

    always_comb
    begin
        state_next        = state_reg;
        ack_next          = ack_reg;
        nak_next          = nak_reg;
        can_next          = can_reg;
        wr_next           = wr_reg;
        status_next       = status_reg;
        addr_next         = addr_reg;
        word_next         = word_reg;
        cmd_pop           = 1'b0;
        back_stat.wr_done = 1'b0;
        load_out          = 1'b0;
        kind_next         = xcr_pkg::KIND_REPLY;
        last_next         = 1'b0;
        tx_next           = '0;
        waddr_next        = '0;
        wdata_next        = '0;
        ostat_next        = status_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop     = 1'b1;
                    ack_next    = cmd.n_ack;
                    nak_next    = cmd.nak;
                    can_next    = cmd.can;
                    wr_next     = cmd.wr;
                    status_next = cmd.status;
                    addr_next   = base_reg + {32'd0, cmd.offset};
                    word_next   = '0;
                    state_next  = S_REPLY;
                end
            end
            S_REPLY:
            begin
                if (nak_reg)
                begin
                    if (out_free)
                    begin
                        load_out  = 1'b1;
                        tx_next   = xcr_pkg::B_NAK;
                        last_next = (ack_reg == 2'd0) && !can_reg && !wr_reg;
                        nak_next  = 1'b0;
                    end
                end
                else if (ack_reg != 2'd0)
                begin
                    if (out_free)
                    begin
                        load_out  = 1'b1;
                        tx_next   = xcr_pkg::B_ACK;
                        last_next = (ack_reg == 2'd1) && !can_reg && !wr_reg;
                        ack_next  = ack_reg - 2'd1;
                    end
                end
                else if (can_reg)
                begin
                    if (out_free)
                    begin
                        load_out  = 1'b1;
                        tx_next   = xcr_pkg::B_CAN;
                        last_next = !wr_reg;
                        can_next  = 1'b0;
                    end
                end
                else
                begin
                    state_next = wr_reg ? S_READ : S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    kind_next  = xcr_pkg::KIND_WRITE;
                    waddr_next = addr_reg;
                    wdata_next = rd_data_reg;
                    last_next  = (word_reg == xcr_pkg::WORD_LAST);
                    addr_next  = addr_reg + xcr_pkg::WORD_STRIDE;
                    word_next  = word_reg + 1'b1;
                    if (word_reg == xcr_pkg::WORD_LAST)
                    begin
                        wr_next           = 1'b0;
                        back_stat.wr_done = 1'b1;
                        state_next        = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        valid_next = load_out || (valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ack_reg   <= '0;
            nak_reg   <= 1'b0;
            can_reg   <= 1'b0;
            wr_reg    <= 1'b0;
            valid_reg <= 1'b0;
            base_reg  <= xcr_pkg::LOAD_BASE_RST;
        end
        else
        begin
            state_reg <= state_next;
            ack_reg   <= ack_next;
            nak_reg   <= nak_next;
            can_reg   <= can_next;
            wr_reg    <= wr_next;
            valid_reg <= valid_next;
            if (load_base_we)
            begin
                base_reg <= load_base_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        addr_reg   <= addr_next;
        word_reg   <= word_next;
        if (load_out)
        begin
            kind_reg  <= kind_next;
            last_reg  <= last_next;
            tx_reg    <= tx_next;
            waddr_reg <= waddr_next;
            wdata_reg <= wdata_next;
            ostat_reg <= ostat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr.en)
        begin
            store_mem[mem_wr.addr] <= mem_wr.data;
        end
        rd_data_reg <= store_mem[word_reg];
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {5'd0, ostat_reg, wdata_reg, waddr_reg, tx_reg};

`ifndef SYNTHESIS
    a_write_only_while_running: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && kind_reg == xcr_pkg::KIND_WRITE) |-> ostat_reg == xcr_pkg::ST_RUN)
        else $error("data write issued for a session that has ended");

    a_read_then_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |=> state_reg == S_WRITE)
        else $error("store read not followed by its write transaction");

    a_no_pop_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !nak_reg && ack_reg == 2'd0 && !can_reg && !wr_reg)
        else $error("command taken before the previous one finished");
`endif

endmodule

// File: sv/xmodem_checksum_receiver_top.sv
// Throughput: one input transaction per cycle while the command queue has room and no
// writes are draining, replies one per cycle while m_tready is high; after a good packet
// input holds off while its 16 writes drain, each through the data store read port.
// Reset (rst_n, asynchronous, active low) idles the session, empties the command queue
// and sets load_base to 0x200000000; the data store is not cleared.
// ----------------------------------------------------------------------------
// XMODEM checksum receiver top level
// Front end, command queue and back end of a receiver for 132-byte XMODEM
// checksum packets that replies to the sender and writes verified data.
// ----------------------------------------------------------------------------
module xmodem_checksum_receiver_top
#(
    parameter int CMD_DEPTH = xcr_pkg::CMD_DEPTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load_base_we,
    input  logic [63:0]                       load_base_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [xcr_pkg::IN_DATA_W-1:0]     s_tdata,   // rx_byte[7:0]
    input  logic [1:0]                        s_tuser,   // action[1:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [xcr_pkg::OUT_DATA_W-1:0]    m_tdata,   // tx_byte[7:0], write_addr[71:8],
                                                         // write_data[135:72],
                                                         // session_status[138:136]
    output logic                              m_tuser,   // kind
    output logic                              m_tlast
);

    xcr_pkg::cmd_t       push_cmd;
    xcr_pkg::cmd_t       head_cmd;
    logic                cmd_push;
    logic                cmd_pop;
    logic                cmd_full;
    logic                cmd_empty;
    xcr_pkg::mem_wr_t    mem_wr;
    xcr_pkg::back_stat_t back_stat;

    xcr_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (push_cmd),
        .cmd_push  (cmd_push),
        .cmd_full  (cmd_full),
        .mem_wr    (mem_wr),
        .back_stat (back_stat)
    );

    xcr_cmd_fifo
    #(
        .DEPTH (CMD_DEPTH)
    )
    u_cmd_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (push_cmd),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_data  (head_cmd),
        .empty     (cmd_empty)
    );

    xcr_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .load_base_we    (load_base_we),
        .load_base_wdata (load_base_wdata),
        .cmd             (head_cmd),
        .cmd_empty       (cmd_empty),
        .cmd_pop         (cmd_pop),
        .mem_wr          (mem_wr),
        .back_stat       (back_stat),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast)
    );

endmodule
